// ===== sv/vnorm_pkg.sv =====
package vnorm_pkg;

    localparam int COMPONENT_WIDTH = 16;
    localparam int FRACTION_BITS   = 14;
    localparam int OUT_WIDTH       = FRACTION_BITS + 2;
    localparam int SQ_WIDTH        = 2 * COMPONENT_WIDTH;
    localparam int ACC_WIDTH       = 2 * FRACTION_BITS + 2 * COMPONENT_WIDTH + 4;
    localparam int ROOT_STAGES     = FRACTION_BITS + 1;

    // Running state of the digit recurrence for one component.
    // acc holds (2q-1)^2 * sum and lin holds (2q-1) * sum.
    typedef struct packed {
        logic [FRACTION_BITS:0]        q;
        logic signed [ACC_WIDTH-1:0]   acc;
        logic signed [ACC_WIDTH-1:0]   lin;
    } root_state_t;

    // One digit: set bit b of q if q is below 2^F and the scaled square stays within
    // the bound. The square is updated from the previous one by shifts and adds.
    function automatic root_state_t root_step(root_state_t cur,
                                              logic [SQ_WIDTH-1:0] sum,
                                              logic signed [ACC_WIDTH-1:0] bound,
                                              int b);
        logic signed [ACC_WIDTH-1:0] sum_ext;
        logic signed [ACC_WIDTH-1:0] cand;
        logic                        allowed;
        root_state_t                 nxt;
        sum_ext = $signed(ACC_WIDTH'(sum));
        cand    = cur.acc + (cur.lin <<< (b + 2)) + (sum_ext <<< (2 * b + 2));
        allowed = (b == FRACTION_BITS) || !cur.q[FRACTION_BITS];
        nxt     = cur;
        if (allowed && (cand <= bound)) begin
            nxt.q   = cur.q | ((FRACTION_BITS + 1)'(1) << b);
            nxt.acc = cand;
            nxt.lin = cur.lin + (sum_ext <<< (b + 1));
        end
        return nxt;
    endfunction

endpackage

// ===== sv/vnorm_root_pipe.sv =====
module vnorm_root_pipe (
    input  logic                                     aclk,
    input  logic                                     en,
    input  logic [vnorm_pkg::SQ_WIDTH-1:0]           sum,
    input  logic signed [vnorm_pkg::ACC_WIDTH-1:0]   bound,
    output logic [vnorm_pkg::FRACTION_BITS:0]        q
);
    import vnorm_pkg::*;

    root_state_t                 st_reg    [ROOT_STAGES];
    logic [SQ_WIDTH-1:0]         sum_reg   [ROOT_STAGES];
    logic signed [ACC_WIDTH-1:0] bound_reg [ROOT_STAGES];
    root_state_t                 init_st;

    always_comb begin
        init_st.q   = '0;
        init_st.acc = $signed(ACC_WIDTH'(sum));
        init_st.lin = -$signed(ACC_WIDTH'(sum));
    end

    for (genvar g = 0; g < ROOT_STAGES; g++) begin : g_stage
        root_state_t                 st_next;
        logic [SQ_WIDTH-1:0]         sum_in;
        logic signed [ACC_WIDTH-1:0] bound_in;
        if (g == 0) begin : g_first
            assign st_next  = root_step(init_st, sum, bound, FRACTION_BITS);
            assign sum_in   = sum;
            assign bound_in = bound;
        end else begin : g_rest
            assign st_next  = root_step(st_reg[g-1], sum_reg[g-1], bound_reg[g-1],
                                        FRACTION_BITS - g);
            assign sum_in   = sum_reg[g-1];
            assign bound_in = bound_reg[g-1];
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[g]    <= st_next;
                sum_reg[g]   <= sum_in;
                bound_reg[g] <= bound_in;
            end
        end
    end

    assign q = st_reg[ROOT_STAGES-1].q;

endmodule

// ===== sv/vector3_normalize_unit.sv =====
// Normalizes one signed three-component vector per item to unit length, giving each
// component as signed fixed point with FRACTION_BITS fraction bits, rounded to nearest
// with ties away from zero and exact for every input. A zero vector gives zero components
// with the flag in m_tuser set. One item is accepted every cycle while the output is not
// stalled. Three stages form the magnitudes, the squares and their sum. FRACTION_BITS + 1
// stages each settle one result bit of the digit recurrence, and one register holds the
// result. The whole pipeline holds while a result waits on m_tready, and s_tready drops
// with it.
module vector3_normalize_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // in_x, in_y, in_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // unit_x, unit_y, unit_z
    output logic        m_tuser    // zero_length
);
    import vnorm_pkg::*;

    logic en;

    logic                       a_valid_reg;
    logic [COMPONENT_WIDTH-1:0] a_mag_reg [3];
    logic                       a_neg_reg [3];

    logic                       b_valid_reg;
    logic [SQ_WIDTH-1:0]        b_sq_reg  [3];
    logic                       b_neg_reg [3];

    logic                        c_valid_reg;
    logic [SQ_WIDTH-1:0]         c_sum_reg;
    logic signed [ACC_WIDTH-1:0] c_bound_reg [3];
    logic                        c_neg_reg   [3];
    logic                        c_zero_reg;

    logic d_valid_reg [ROOT_STAGES];
    logic d_zero_reg  [ROOT_STAGES];
    logic [2:0] d_neg_reg [ROOT_STAGES];

    logic [FRACTION_BITS:0] q [3];

    logic                 out_valid_reg;
    logic [OUT_WIDTH-1:0] out_unit_reg [3];
    logic                 out_zero_reg;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                a_neg_reg[i] <= s_tdata[i*COMPONENT_WIDTH + COMPONENT_WIDTH - 1];
                a_mag_reg[i] <= s_tdata[i*COMPONENT_WIDTH + COMPONENT_WIDTH - 1]
                              ? COMPONENT_WIDTH'(-s_tdata[i*COMPONENT_WIDTH +: COMPONENT_WIDTH])
                              : s_tdata[i*COMPONENT_WIDTH +: COMPONENT_WIDTH];
                b_sq_reg[i]    <= SQ_WIDTH'(a_mag_reg[i]) * SQ_WIDTH'(a_mag_reg[i]);
                b_neg_reg[i]   <= a_neg_reg[i];
                c_bound_reg[i] <= $signed(ACC_WIDTH'(b_sq_reg[i]) << (2 * FRACTION_BITS + 2));
                c_neg_reg[i]   <= b_neg_reg[i];
            end
            c_sum_reg  <= b_sq_reg[0] + b_sq_reg[1] + b_sq_reg[2];
            c_zero_reg <= (b_sq_reg[0] == '0) && (b_sq_reg[1] == '0) && (b_sq_reg[2] == '0);
            d_zero_reg[0] <= c_zero_reg;
            d_neg_reg[0]  <= {c_neg_reg[2], c_neg_reg[1], c_neg_reg[0]};
            for (int s = 1; s < ROOT_STAGES; s++) begin
                d_zero_reg[s] <= d_zero_reg[s-1];
                d_neg_reg[s]  <= d_neg_reg[s-1];
            end
            for (int i = 0; i < 3; i++) begin
                if (d_zero_reg[ROOT_STAGES-1]) begin
                    out_unit_reg[i] <= '0;
                end else if (d_neg_reg[ROOT_STAGES-1][i]) begin
                    out_unit_reg[i] <= -OUT_WIDTH'(q[i]);
                end else begin
                    out_unit_reg[i] <= OUT_WIDTH'(q[i]);
                end
            end
            out_zero_reg <= d_zero_reg[ROOT_STAGES-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int s = 0; s < ROOT_STAGES; s++) begin
                d_valid_reg[s] <= 1'b0;
            end
        end else if (en) begin
            a_valid_reg    <= s_tvalid;
            b_valid_reg    <= a_valid_reg;
            c_valid_reg    <= b_valid_reg;
            d_valid_reg[0] <= c_valid_reg;
            for (int s = 1; s < ROOT_STAGES; s++) begin
                d_valid_reg[s] <= d_valid_reg[s-1];
            end
            out_valid_reg <= d_valid_reg[ROOT_STAGES-1];
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_comp
        vnorm_root_pipe u_root (
            .aclk  (aclk),
            .en    (en),
            .sum   (c_sum_reg),
            .bound (c_bound_reg[i]),
            .q     (q[i])
        );
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_unit_reg[2], out_unit_reg[1], out_unit_reg[0]};
    assign m_tuser  = out_zero_reg;

    a_zero_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("zero-length result carries nonzero components");

    a_unit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(out_unit_reg[0]) <= $signed(OUT_WIDTH'(1) << FRACTION_BITS)
                  && $signed(out_unit_reg[0]) >= -$signed(OUT_WIDTH'(1) << FRACTION_BITS)))
        else $error("unit component out of range");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    a_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !$past(m_tvalid)) |-> $past(d_valid_reg[ROOT_STAGES-1]))
        else $error("result appeared without an item in the last stage");

    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && c_valid_reg) |=> d_valid_reg[0])
        else $error("item lost entering the root stages");

endmodule

// ===== verif/testbench.sv =====
module testbench;
    import vnorm_pkg::*;

    typedef struct {
        logic signed [15:0] ux;
        logic signed [15:0] uy;
        logic signed [15:0] uz;
        logic               zero;
    } unit_vec_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        m_tuser;

    vector3_normalize_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    logic [47:0] vec_queue[$];
    unit_vec_t   unit_queue[$];
    int          errors = 0;
    int          cycles = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          hold_left = 0;
    bit          hold_req = 0;
    bit          drain_req = 0;
    bit          in_taken = 0;

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    // Largest q in 0..2^F with (2q-1)^2 * sum <= mag^2 * 2^(2F+2).
    function automatic logic [15:0] unit_magnitude(longint unsigned mag,
                                                   longint unsigned sum);
        logic [127:0] lhs;
        logic [127:0] rhs;
        longint unsigned q;
        longint unsigned t;
        q = 0;
        rhs = 128'(mag * mag) << (2 * FRACTION_BITS + 2);
        for (int b = FRACTION_BITS; b >= 0; b--) begin
            t = q | (64'd1 << b);
            if (t <= (64'd1 << FRACTION_BITS)) begin
                lhs = 128'((2 * t - 1) * (2 * t - 1)) * 128'(sum);
                if (lhs <= rhs) q = t;
            end
        end
        return q[15:0];
    endfunction

    function automatic unit_vec_t normalize(logic [47:0] v);
        unit_vec_t r;
        longint signed c[3];
        longint unsigned m[3];
        longint unsigned sum;
        logic [15:0] q[3];
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            c[i] = $signed(v[16*i +: 16]);
            m[i] = c[i] < 0 ? -c[i] : c[i];
            sum += m[i] * m[i];
        end
        if (sum == 0) begin
            r.ux = 0; r.uy = 0; r.uz = 0; r.zero = 1;
            return r;
        end
        for (int i = 0; i < 3; i++) begin
            q[i] = unit_magnitude(m[i], sum);
            if (c[i] < 0) q[i] = -q[i];
        end
        r.ux = q[0]; r.uy = q[1]; r.uz = q[2]; r.zero = 0;
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
    endtask

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($signed($urandom_range(0, 6)) - 3);
            3: return 16'($urandom_range(0, 255)) ^ {16{$urandom_range(0, 1) == 1}};
            default: return 16'($urandom);
        endcase
    endfunction

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 0;
        end else begin
            if (s_tvalid && !in_taken) begin
                s_tvalid <= 1;
            end else if (drain_req && vec_queue.size() > 0 && unit_queue.size() > 0) begin
                s_tvalid <= 0;
            end else if (gap_left > 0 && !hold_req) begin
                gap_left--;
                s_tvalid <= 0;
            end else if (vec_queue.size() > 0) begin
                drain_req = 0;
                s_tvalid <= 1;
                s_tdata <= vec_queue[0];
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 30);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                end
            end else begin
                s_tvalid <= 0;
            end
        end
    end

    // Receiver stall pattern, with one long hold-off.
    always @(negedge aclk) begin
        if (hold_req && hold_left == 0) begin
            hold_left = 200;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 0;
        end else if (cycles % 512 < 150) begin
            m_tready <= 1;
        end else begin
            m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge aclk) begin
        unit_vec_t want;
        cycles++;
        in_taken = aresetn && s_tvalid && s_tready;
        if (in_taken) begin
            unit_queue.push_back(normalize(s_tdata));
            void'(vec_queue.pop_front());
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (unit_queue.size() == 0) begin
                report("unexpected item", m_tdata[31:0], 0);
            end else begin
                want = unit_queue.pop_front();
                if (m_tdata[15:0] !== want.ux) report("unit_x", m_tdata[15:0], want.ux);
                if (m_tdata[31:16] !== want.uy) report("unit_y", m_tdata[31:16], want.uy);
                if (m_tdata[47:32] !== want.uz) report("unit_z", m_tdata[47:32], want.uz);
                if (m_tuser !== want.zero) report("zero_length", m_tuser, want.zero);
            end
        end
        if (cycles > 400000) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial begin
        logic [15:0] edges[6];
        edges = '{16'h0000, 16'h0001, 16'hffff, 16'h7fff, 16'h8000, 16'h5555};
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = 0;
        m_tready = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        // Zero vector, extremes, axis-aligned, a 3-4-5 triangle and equal components.
        vec_queue.push_back(48'h0);
        for (int i = 0; i < 20; i++)
            vec_queue.push_back({edges[$urandom_range(0, 5)], edges[(i + 2) % 6], edges[i % 6]});
        vec_queue.push_back({16'h0003, 16'h0004, 16'h0000});
        vec_queue.push_back({16'h8000, 16'h8000, 16'h8000});
        vec_queue.push_back({16'h7fff, 16'h7fff, 16'h7fff});
        for (int i = 0; i < 1700; i++)
            vec_queue.push_back({rand_comp(), rand_comp(), rand_comp()});
        wait (vec_queue.size() < 1200);
        @(posedge aclk);
        hold_req = 1;
        wait (vec_queue.size() < 600);
        @(posedge aclk);
        drain_req = 1;
        wait (vec_queue.size() == 0 && unit_queue.size() == 0);
        repeat (60) @(posedge aclk);
        if (errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end
endmodule
